/* sv/cgp_netlist_evaluator_assert.svh */
// Assertion macros for the netlist evaluator modules.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef CGP_NETLIST_EVALUATOR_ASSERT_SVH
`define CGP_NETLIST_EVALUATOR_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CGP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be true outside reset.
`define CGP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* sv/cgp_pkg.sv */
// Shared types, constants and gate functions of the netlist evaluator.
// No dependencies; used by the controller, the datapath and the top level.
package cgp_pkg;

  localparam int NUM_NODES_DEF = 128;
  localparam int NUM_INPUTS    = 4;
  localparam int MAX_OUTPUTS   = 4;
  localparam int SEL_REGS      = 4;
  localparam int SEL_W         = 2;
  localparam int ROW_BITS      = 4;
  localparam int ADDR_W        = 8;
  localparam int GATE_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;
  localparam int USED_LIMIT    = (MAX_OUTPUTS < SEL_REGS) ? MAX_OUTPUTS : SEL_REGS;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_type_e;

  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_REJECT = 1'b1
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_OUTPUTS = 3'd0,
    CFG_OUT_SEL_0   = 3'd1,
    CFG_OUT_SEL_1   = 3'd2,
    CFG_OUT_SEL_2   = 3'd3,
    CFG_OUT_SEL_3   = 3'd4
  } cfg_reg_e;

  typedef enum logic [GATE_W-1:0] {
    GATE_AND      = 4'd0,
    GATE_OR       = 4'd1,
    GATE_NAND     = 4'd2,
    GATE_NOR      = 4'd3,
    GATE_XOR      = 4'd4,
    GATE_XNOR     = 4'd5,
    GATE_A_ANDN_B = 4'd6,
    GATE_A        = 4'd7,
    GATE_B_ANDN_A = 4'd8,
    GATE_B        = 4'd9,
    GATE_NOT_B    = 4'd10,
    GATE_A_ORN_B  = 4'd11,
    GATE_NOT_A    = 4'd12,
    GATE_B_ORN_A  = 4'd13
  } gate_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_DRAIN,
    ST_GATHER,
    ST_GWAIT,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic                req_type;
    logic [6:0]          gene_index;
    logic [ADDR_W-1:0]   conn_first;
    logic [ADDR_W-1:0]   conn_second;
    logic [GATE_W-1:0]   gate_code;
    logic [ROW_BITS-1:0] row_inputs;
    logic [SEL_REGS-1:0] expected_bits;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [SEL_REGS-1:0] output_bits;
    logic [2:0]          match_count;
  } res_t;

  typedef struct packed {
    logic [GATE_W-1:0] gate;
    logic [ADDR_W-1:0] src_b;
    logic [ADDR_W-1:0] src_a;
  } gene_t;

  typedef struct packed {
    logic [2:0]                       num_outputs;
    logic [SEL_REGS-1:0][ADDR_W-1:0] out_sel;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic load_exec;
    logic eval_issue;
    logic gath_issue;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic pipe_busy;
    logic gath_last;
    logic used_zero;
  } dp_status_t;

  // Primary input bit; inputs beyond the row field read as zero.
  function automatic logic row_bit(logic [ADDR_W-1:0] addr, logic [ROW_BITS-1:0] row);
    logic bit_v;
    bit_v = 1'b0;
    if (int'(addr) < NUM_INPUTS && int'(addr) < ROW_BITS) begin
      bit_v = row[addr[1:0]];
    end
    return bit_v;
  endfunction

  function automatic logic gate_eval(logic [GATE_W-1:0] code, logic a, logic b);
    logic r;
    unique case (gate_e'(code))
      GATE_AND:      r = a & b;
      GATE_OR:       r = a | b;
      GATE_NAND:     r = ~(a & b);
      GATE_NOR:      r = ~(a | b);
      GATE_XOR:      r = a ^ b;
      GATE_XNOR:     r = ~(a ^ b);
      GATE_A_ANDN_B: r = a & ~b;
      GATE_A:        r = a;
      GATE_B_ANDN_A: r = ~a & b;
      GATE_B:        r = b;
      GATE_NOT_B:    r = ~b;
      GATE_A_ORN_B:  r = a | ~b;
      GATE_NOT_A:    r = ~a;
      GATE_B_ORN_A:  r = b | ~a;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* sv/cgp_ctrl.sv */
// Controller state machine of the netlist evaluator.
// Depends on cgp_pkg and the assertion macro header.
`include "cgp_netlist_evaluator_assert.svh"

module cgp_ctrl import cgp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       is_eval_i,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  ctl_state_e state_q, state_d;
  logic       done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = is_eval_i ? ST_EVAL : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_exec = 1'b1;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_EVAL: begin
        cmd_o.eval_issue = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Wait for the last node to be written before the outputs are read.
        if (!status_i.pipe_busy) begin
          state_d = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (status_i.used_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.gath_issue = 1'b1;
          if (status_i.gath_last) begin
            state_d = ST_GWAIT;
          end
        end
      end
      ST_GWAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  `CGP_ASSERT(a_done_single, done_q |=> !done_q, "result strobe lasted more than one cycle")
  `CGP_ASSERT(a_accept_busy, start_i && !busy_o |=> busy_o, "accepted request did not raise busy")
  `CGP_ASSERT(a_finish_done, state_q == ST_FINISH |=> done_q, "evaluation finished without result")

endmodule

/* sv/cgp_dpath.sv */
// Datapath of the netlist evaluator: gene store, node value memory,
// three-stage node pipeline and output gathering. Depends on cgp_pkg.
`include "cgp_netlist_evaluator_assert.svh"

module cgp_dpath import cgp_pkg::*; #(
  parameter int NUM_NODES = NUM_NODES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t status_o,
  input  req_t       req_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

  gene_t gene_mem [NUM_NODES];
  logic  node_mem [NUM_NODES];

  req_t    req_q;
  res_t    res_q;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          cnt_last;

  // Request register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  assign cnt_last = (cnt_q == NW'(NUM_NODES - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clr_wr || cmd_i.eval_issue) begin
      cnt_d = cnt_last ? '0 : cnt_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Load check: both sources must be primary inputs or earlier nodes.
  logic [8:0] limit;
  logic       load_ok;
  gene_t      new_gene;

  assign limit    = 9'(NUM_INPUTS) + 9'(req_q.gene_index);
  assign load_ok  = (int'(req_q.gene_index) < NUM_NODES)
                 && ({1'b0, req_q.conn_first} < limit)
                 && ({1'b0, req_q.conn_second} < limit);
  assign new_gene = '{gate: req_q.gate_code, src_b: req_q.conn_second,
                      src_a: req_q.conn_first};

  gene_t gene_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      gene_mem[cnt_q] <= '0;
    end else if (cmd_i.load_exec && load_ok) begin
      gene_mem[NW'(req_q.gene_index)] <= new_gene;
    end
    if (cmd_i.eval_issue) begin
      gene_rd_q <= gene_mem[cnt_q];
    end
  end

  // Stage A: decode the sources of the node whose gene was just read.
  logic          s1_vld_q, s2_vld_q;
  logic [NW-1:0] s1_idx_q, s2_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.eval_issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  logic [ADDR_W-1:0] off_a, off_b;
  logic              node_a, node_b, fwd_a, fwd_b;

  assign off_a  = gene_rd_q.src_a - ADDR_W'(NUM_INPUTS);
  assign off_b  = gene_rd_q.src_b - ADDR_W'(NUM_INPUTS);
  assign node_a = (int'(gene_rd_q.src_a) >= NUM_INPUTS) && (int'(off_a) < NUM_NODES);
  assign node_b = (int'(gene_rd_q.src_b) >= NUM_INPUTS) && (int'(off_b) < NUM_NODES);
  // The previous node is written in this very cycle, so its value is forwarded.
  assign fwd_a  = node_a && (int'(off_a) + 1 == int'(s1_idx_q));
  assign fwd_b  = node_b && (int'(off_b) + 1 == int'(s1_idx_q));

  logic [GATE_W-1:0] s2_gate_q;
  logic              s2_a_node_q, s2_b_node_q, s2_a_fwd_q, s2_b_fwd_q;
  logic              s2_a_in_q, s2_b_in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_issue) begin
      s1_idx_q <= cnt_q;
    end
    if (s1_vld_q) begin
      s2_idx_q    <= s1_idx_q;
      s2_gate_q   <= gene_rd_q.gate;
      s2_a_node_q <= node_a;
      s2_b_node_q <= node_b;
      s2_a_fwd_q  <= fwd_a;
      s2_b_fwd_q  <= fwd_b;
      s2_a_in_q   <= row_bit(gene_rd_q.src_a, req_q.row_inputs);
      s2_b_in_q   <= row_bit(gene_rd_q.src_b, req_q.row_inputs);
    end
  end

  // Gather addressing for the selected outputs.
  logic [SEL_W-1:0]  sel_q, sel_d;
  logic [2:0]        used;
  logic              gath_last;
  logic [ADDR_W-1:0] g_addr, g_off;
  logic              g_node;

  assign used      = (int'(cfg_i.num_outputs) > USED_LIMIT) ? 3'(USED_LIMIT)
                                                           : cfg_i.num_outputs;
  assign gath_last = ({1'b0, sel_q} == used - 3'd1);
  assign g_addr    = cfg_i.out_sel[sel_q];
  assign g_off     = g_addr - ADDR_W'(NUM_INPUTS);
  assign g_node    = (int'(g_addr) >= NUM_INPUTS) && (int'(g_off) < NUM_NODES);

  always_comb begin
    sel_d = sel_q;
    if (cmd_i.gath_issue) begin
      sel_d = gath_last ? '0 : sel_q + SEL_W'(1);
    end
  end

  // Node value memory: one write port, two registered read ports.
  logic [NW-1:0] rd_addr_a, rd_addr_b;
  logic          rd_a_q, rd_b_q;
  logic          op_a, op_b, node_val, prev_q;

  assign rd_addr_a = cmd_i.gath_issue ? NW'(g_off) : NW'(off_a);
  assign rd_addr_b = NW'(off_b);

  assign op_a     = s2_a_fwd_q ? prev_q : (s2_a_node_q ? rd_a_q : s2_a_in_q);
  assign op_b     = s2_b_fwd_q ? prev_q : (s2_b_node_q ? rd_b_q : s2_b_in_q);
  assign node_val = gate_eval(s2_gate_q, op_a, op_b);

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      node_mem[s2_idx_q] <= node_val;
      prev_q             <= node_val;
    end
    if (s1_vld_q || cmd_i.gath_issue) begin
      rd_a_q <= node_mem[rd_addr_a];
    end
    if (s1_vld_q) begin
      rd_b_q <= node_mem[rd_addr_b];
    end
  end

  logic             g_vld_q;
  logic [SEL_W-1:0] g_j_q;
  logic             g_node_q, g_in_q;
  logic [SEL_REGS-1:0] bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= '0;
      g_vld_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      g_vld_q <= cmd_i.gath_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gath_issue) begin
      g_j_q    <= sel_q;
      g_node_q <= g_node;
      g_in_q   <= row_bit(g_addr, req_q.row_inputs);
    end
    if (cmd_i.capture) begin
      bits_q <= '0;
    end else if (g_vld_q) begin
      bits_q[g_j_q] <= g_node_q ? rd_a_q : g_in_q;
    end
  end

  logic [2:0] match_cnt;

  always_comb begin
    match_cnt = '0;
    for (int j = 0; j < SEL_REGS; j++) begin
      if (j < int'(used) && bits_q[j] == req_q.expected_bits[j]) begin
        match_cnt = match_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_exec) begin
      res_q.status      <= load_ok ? STATUS_OK : STATUS_REJECT;
      res_q.output_bits <= '0;
      res_q.match_count <= '0;
    end else if (cmd_i.finish) begin
      res_q.status      <= STATUS_OK;
      res_q.output_bits <= bits_q;
      res_q.match_count <= match_cnt;
    end
  end

  assign res_o              = res_q;
  assign status_o.cnt_last  = cnt_last;
  assign status_o.pipe_busy = s1_vld_q | s2_vld_q;
  assign status_o.gath_last = gath_last;
  assign status_o.used_zero = (used == 3'd0);

  `CGP_ASSERT(a_fwd_has_prev, s1_vld_q && (fwd_a || fwd_b) |-> s2_vld_q, "forward without producer")
  `CGP_ASSERT_NEVER(a_gath_in_eval, cmd_i.gath_issue && (s1_vld_q || s2_vld_q), "gather during eval")
  `CGP_ASSERT(a_node_order, s1_vld_q && s2_vld_q |-> s1_idx_q == s2_idx_q + NW'(1), "node order broken")

endmodule

/* sv/cgp_netlist_evaluator.sv */
// Cartesian genetic programming netlist evaluator: a load request is executed in the
// LOAD state before the done_o strobe; an evaluate request walks the genes one node
// per cycle through a 3-stage pipe, then drains it and gathers the outputs in use.
// A new request is accepted in the cycle its predecessor's result is shown.
// After reset a clearing pass over all NUM_NODES genes zeroes the gene store with busy_o
// high; configuration registers reset to one output and all selects zero.
module cgp_netlist_evaluator import cgp_pkg::*; #(
  parameter int NUM_NODES = NUM_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  req_t                  req_i,
  output logic                  done_o,
  output res_t                  res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_OUTPUTS: cfg_d.num_outputs = cfg_data_i[2:0];
        CFG_OUT_SEL_0:   cfg_d.out_sel[0]  = cfg_data_i;
        CFG_OUT_SEL_1:   cfg_d.out_sel[1]  = cfg_data_i;
        CFG_OUT_SEL_2:   cfg_d.out_sel[2]  = cfg_data_i;
        CFG_OUT_SEL_3:   cfg_d.out_sel[3]  = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_outputs <= 3'd1;
      cfg_q.out_sel     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  cgp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .is_eval_i (req_i.req_type == REQ_EVAL),
    .status_i  (dp_status),
    .cmd_o     (cmd),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  cgp_dpath #(
    .NUM_NODES (NUM_NODES)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (dp_status),
    .req_i    (req_i),
    .cfg_i    (cfg_q),
    .res_o    (res_o)
  );

endmodule
